// File: rtl/dlch_pkg.sv
// dlch_pkg: shared types, constants and level helper for the distance level classifier
// no dependencies; used by distance_level_classifier_hysteresis

package dlch_pkg;

  localparam int NUM_ENTITIES = 256;
  localparam int IDX_W        = $clog2(NUM_ENTITIES);

  localparam int DIST_W   = 16;
  localparam int SCALE_W  = 9;
  localparam int MARGIN_W = 12;
  localparam int LVL_W    = 2;
  localparam int LIM_W    = DIST_W + 1;
  localparam int THR_W    = LIM_W + SCALE_W;
  localparam int NEAR_W   = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  localparam logic [DIST_W-1:0]  NEAR_MIN    = DIST_W'(50);
  localparam logic [LIM_W-1:0]   MID_GAP     = LIM_W'(100);
  localparam logic [LIM_W-1:0]   FAR_GAP     = LIM_W'(500);
  localparam logic [SCALE_W-1:0] SCALE_MIN   = SCALE_W'(77);
  localparam logic [SCALE_W-1:0] SCALE_MAX   = SCALE_W'(384);

  localparam logic [DIST_W-1:0]   NEAR_RST   = DIST_W'(500);
  localparam logic [DIST_W-1:0]   MID_RST    = DIST_W'(2000);
  localparam logic [DIST_W-1:0]   FAR_RST    = DIST_W'(10000);
  localparam logic [SCALE_W-1:0]  SCALE_RST  = SCALE_W'(256);
  localparam logic [MARGIN_W-1:0] MARGIN_RST = MARGIN_W'(50);

  localparam logic [LVL_W-1:0] LVL_FULL   = 2'd0;
  localparam logic [LVL_W-1:0] LVL_SIMPLE = 2'd1;
  localparam logic [LVL_W-1:0] LVL_AGGR   = 2'd2;
  localparam logic [LVL_W-1:0] LVL_FROZEN = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEAR   = 3'd0,
    CFG_MID    = 3'd1,
    CFG_FAR    = 3'd2,
    CFG_SCALE  = 3'd3,
    CFG_MARGIN = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEAR,
    ST_MID,
    ST_FAR,
    ST_MUL,
    ST_CMP
  } state_t;

  function automatic logic [LVL_W-1:0] level_for(
    input logic [THR_W-1:0] lhs,
    input logic             mov,
    input logic [THR_W-1:0] t1,
    input logic [THR_W-1:0] t2,
    input logic [THR_W-1:0] t3
  );
    logic [LVL_W-1:0] lvl;
    if (!mov) begin
      lvl = (lhs > t3) ? LVL_FROZEN : LVL_AGGR;
    end else if (lhs < t1) begin
      lvl = LVL_FULL;
    end else if (lhs < t2) begin
      lvl = LVL_SIMPLE;
    end else begin
      lvl = LVL_AGGR;
    end
    return lvl;
  endfunction

endpackage

// File: rtl/distance_level_classifier_hysteresis.sv
// distance_level_classifier_hysteresis: per-entity detail level with hysteresis
// keeps last levels in a 256x2 synchronous ram; depends on dlch_pkg
//
// sequence: accept in idle, clamp the near/mid/far radii, multiply them by the scale, then
// compare and load the output register; a new word is taken only after the result is handed
// over, so words pass one at a time through the single level ram read-modify-write
// reset: synchronous; all entity levels read as 0 through per-entry valid bits,
// config registers return to their defaults, no clearing pass

module distance_level_classifier_hysteresis (
  input  logic                              clk,
  input  logic                              rst,
  // config write port
  input  logic                              cfg_we,
  input  logic [dlch_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dlch_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input words
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [dlch_pkg::IN_DATA_W-1:0]    s_tdata,  // entity_index, distance_m, moving, priority_req
  // output words
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [dlch_pkg::OUT_DATA_W-1:0]   m_tdata   // level, scaled_near_distance
);

  localparam int IW = dlch_pkg::IDX_W;
  localparam int DW = dlch_pkg::DIST_W;
  localparam int LW = dlch_pkg::LIM_W;
  localparam int TW = dlch_pkg::THR_W;
  localparam int VW = dlch_pkg::LVL_W;

  // config registers
  logic [DW-1:0]                    near_distance;
  logic [DW-1:0]                    mid_distance;
  logic [DW-1:0]                    far_distance;
  logic [dlch_pkg::SCALE_W-1:0]     range_scale;
  logic [dlch_pkg::MARGIN_W-1:0]    hysteresis_margin;
  logic [dlch_pkg::SCALE_W-1:0]     scale_sat;

  // level ram and valid bits
  logic [VW-1:0]                    lvl_mem [dlch_pkg::NUM_ENTITIES];
  logic [dlch_pkg::NUM_ENTITIES-1:0] vld;
  logic [VW-1:0]                    mem_q;
  logic                             vld_q;
  logic                             mem_we;

  // item registers
  dlch_pkg::state_t                 state, state_next;
  logic [IW-1:0]                    idx;
  logic [DW-1:0]                    distance;
  logic                             mov;
  logic                             pri;
  logic [VW-1:0]                    last;
  logic [LW-1:0]                    l1, l2, l3;
  logic [TW-1:0]                    t1, t2, t3;
  logic                             accept;
  logic                             load_out;

  // compare stage
  logic [TW-1:0]                    lhs_raw, lhs_m;
  logic [LW-1:0]                    dist_m;
  logic [VW-1:0]                    raw, strict, lvl;

  // output register
  logic [VW-1:0]                    out_level;
  logic [dlch_pkg::NEAR_W-1:0]      out_near;

  assign scale_sat = (cfg_data[dlch_pkg::SCALE_W-1:0] < dlch_pkg::SCALE_MIN) ? dlch_pkg::SCALE_MIN :
                     (cfg_data[dlch_pkg::SCALE_W-1:0] > dlch_pkg::SCALE_MAX) ? dlch_pkg::SCALE_MAX :
                     cfg_data[dlch_pkg::SCALE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      near_distance     <= dlch_pkg::NEAR_RST;
      mid_distance      <= dlch_pkg::MID_RST;
      far_distance      <= dlch_pkg::FAR_RST;
      range_scale       <= dlch_pkg::SCALE_RST;
      hysteresis_margin <= dlch_pkg::MARGIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dlch_pkg::CFG_NEAR:   near_distance     <= cfg_data;
        dlch_pkg::CFG_MID:    mid_distance      <= cfg_data;
        dlch_pkg::CFG_FAR:    far_distance      <= cfg_data;
        dlch_pkg::CFG_SCALE:  range_scale       <= scale_sat;
        dlch_pkg::CFG_MARGIN: hysteresis_margin <= cfg_data[dlch_pkg::MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      dlch_pkg::ST_IDLE: if (s_tvalid) state_next = dlch_pkg::ST_NEAR;
      dlch_pkg::ST_NEAR: state_next = dlch_pkg::ST_MID;
      dlch_pkg::ST_MID:  state_next = dlch_pkg::ST_FAR;
      dlch_pkg::ST_FAR:  state_next = dlch_pkg::ST_MUL;
      dlch_pkg::ST_MUL:  state_next = dlch_pkg::ST_CMP;
      dlch_pkg::ST_CMP:  if (!m_tvalid || m_tready) state_next = dlch_pkg::ST_IDLE;
      default:           state_next = dlch_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready = 1'b0;
    load_out = 1'b0;
    case (state)
      dlch_pkg::ST_IDLE: s_tready = 1'b1;
      dlch_pkg::ST_CMP:  load_out = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  assign accept = s_tvalid && s_tready;
  assign mem_we = load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dlch_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ram: registered read at accept, write when the result is handed over
  always_ff @(posedge clk) begin
    if (accept) begin
      mem_q <= lvl_mem[s_tdata[IW-1:0]];
    end
    if (mem_we) begin
      lvl_mem[idx] <= lvl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (mem_we) begin
      vld[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx      <= s_tdata[IW-1:0];
      distance <= s_tdata[8 +: DW];
      mov      <= s_tdata[24];
      pri      <= s_tdata[25];
      vld_q    <= vld[s_tdata[IW-1:0]];
    end
    case (state)
      dlch_pkg::ST_NEAR: begin
        last <= vld_q ? mem_q : dlch_pkg::LVL_FULL;
        l1   <= (near_distance < dlch_pkg::NEAR_MIN) ? LW'(dlch_pkg::NEAR_MIN) : LW'(near_distance);
      end
      dlch_pkg::ST_MID: begin
        l2 <= (LW'(mid_distance) < l1 + dlch_pkg::MID_GAP) ? l1 + dlch_pkg::MID_GAP
                                                            : LW'(mid_distance);
      end
      dlch_pkg::ST_FAR: begin
        l3 <= (LW'(far_distance) < l2 + dlch_pkg::FAR_GAP) ? l2 + dlch_pkg::FAR_GAP
                                                            : LW'(far_distance);
      end
      dlch_pkg::ST_MUL: begin
        t1 <= TW'(l1) * TW'(range_scale);
        t2 <= TW'(l2) * TW'(range_scale);
        t3 <= TW'(l3) * TW'(range_scale);
      end
      default: ;
    endcase
  end

  // raw and hysteresis-reduced levels; a priority request forces full detail
  always_comb begin
    dist_m  = LW'(distance) + LW'(hysteresis_margin);
    lhs_raw = TW'({distance, 8'b0});
    lhs_m   = TW'({dist_m, 8'b0});
    raw     = dlch_pkg::level_for(lhs_raw, mov, t1, t2, t3);
    strict  = dlch_pkg::level_for(lhs_m, mov, t1, t2, t3);
    if (pri) begin
      lvl = dlch_pkg::LVL_FULL;
    end else if (raw >= last) begin
      lvl = raw;
    end else begin
      lvl = (strict < last) ? strict : last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_level <= lvl;
      out_near  <= t1[8 +: dlch_pkg::NEAR_W];
    end
  end

  assign m_tdata = {{(dlch_pkg::OUT_DATA_W - VW - dlch_pkg::NEAR_W){1'b0}}, out_near, out_level};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input taken while an item is in flight");

  a_write_loads_out: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> m_tvalid)
    else $error("level written without a result word");

  a_priority_full: assert property (@(posedge clk) disable iff (rst)
    (load_out && pri) |=> m_tdata[1:0] == dlch_pkg::LVL_FULL)
    else $error("priority entity not at full detail");

  a_cmp_holds: assert property (@(posedge clk) disable iff (rst)
    (state == dlch_pkg::ST_CMP && !load_out) |=> state == dlch_pkg::ST_CMP)
    else $error("result dropped while output stalled");

endmodule

// File: sim/tb_distance_level_classifier_hysteresis.sv
// tb_distance_level_classifier_hysteresis: self-checking bench for the per-entity level
// classifier; a scoreboard class predicts level and scaled near radius for every word
// depends on dlch_pkg and distance_level_classifier_hysteresis

typedef struct packed {
  logic [dlch_pkg::LVL_W-1:0]  level;
  logic [dlch_pkg::NEAR_W-1:0] near_scaled;
} level_word_t;

class level_checker;
  logic [dlch_pkg::DIST_W-1:0]   near_m;
  logic [dlch_pkg::DIST_W-1:0]   mid_m;
  logic [dlch_pkg::DIST_W-1:0]   far_m;
  logic [dlch_pkg::SCALE_W-1:0]  scale_q8;
  logic [dlch_pkg::MARGIN_W-1:0] margin_m;
  logic [dlch_pkg::LVL_W-1:0]    last_lvl [dlch_pkg::NUM_ENTITIES];
  level_word_t                   expected_levels [$];
  int                            errors;
  int                            requests;
  int                            checked;
  int                            held;

  function new();
    near_m   = dlch_pkg::NEAR_RST;
    mid_m    = dlch_pkg::MID_RST;
    far_m    = dlch_pkg::FAR_RST;
    scale_q8 = dlch_pkg::SCALE_RST;
    margin_m = dlch_pkg::MARGIN_RST;
    foreach (last_lvl[i]) last_lvl[i] = dlch_pkg::LVL_FULL;
    errors   = 0;
    requests = 0;
    checked  = 0;
    held     = 0;
  endfunction

  function void write_reg(logic [dlch_pkg::CFG_IDX_W-1:0] idx,
                          logic [dlch_pkg::CFG_DATA_W-1:0] val);
    logic [dlch_pkg::SCALE_W-1:0] s;
    s = val[dlch_pkg::SCALE_W-1:0];
    case (idx)
      dlch_pkg::CFG_NEAR:   near_m = val;
      dlch_pkg::CFG_MID:    mid_m = val;
      dlch_pkg::CFG_FAR:    far_m = val;
      dlch_pkg::CFG_SCALE: begin
        if (s < dlch_pkg::SCALE_MIN) s = dlch_pkg::SCALE_MIN;
        if (s > dlch_pkg::SCALE_MAX) s = dlch_pkg::SCALE_MAX;
        scale_q8 = s;
      end
      dlch_pkg::CFG_MARGIN: margin_m = val[dlch_pkg::MARGIN_W-1:0];
      default: ;
    endcase
  endfunction

  // clamped radius in meters: 0 near, 1 mid, 2 far
  function int unsigned radius_m(int k);
    int unsigned l1, l2, l3;
    l1 = (near_m < dlch_pkg::NEAR_MIN) ? dlch_pkg::NEAR_MIN : near_m;
    l2 = (mid_m < l1 + dlch_pkg::MID_GAP) ? l1 + dlch_pkg::MID_GAP : mid_m;
    l3 = (far_m < l2 + dlch_pkg::FAR_GAP) ? l2 + dlch_pkg::FAR_GAP : far_m;
    return (k == 0) ? l1 : (k == 1) ? l2 : l3;
  endfunction

  function int unsigned scaled_m(int k);
    return (radius_m(k) * scale_q8) >> 8;
  endfunction

  function logic [dlch_pkg::LVL_W-1:0] classify(int unsigned d, int unsigned m, bit mov);
    int unsigned lhs;
    lhs = (d + m) * 256;
    if (!mov) return (lhs > radius_m(2) * scale_q8) ? dlch_pkg::LVL_FROZEN : dlch_pkg::LVL_AGGR;
    if (lhs < radius_m(0) * scale_q8) return dlch_pkg::LVL_FULL;
    if (lhs < radius_m(1) * scale_q8) return dlch_pkg::LVL_SIMPLE;
    return dlch_pkg::LVL_AGGR;
  endfunction

  function void note_request(logic [dlch_pkg::IN_DATA_W-1:0] w);
    int unsigned                idx, d;
    bit                         mov, pri;
    logic [dlch_pkg::LVL_W-1:0] last, raw, strict, lvl;
    level_word_t                e;
    idx = w[7:0] % dlch_pkg::NUM_ENTITIES;
    d   = w[23:8];
    mov = w[24];
    pri = w[25];
    if (pri) begin
      lvl = dlch_pkg::LVL_FULL;
    end else begin
      last = last_lvl[idx];
      raw  = classify(d, 0, mov);
      if (raw >= last) begin
        lvl = raw;
      end else begin
        strict = classify(d, margin_m, mov);
        lvl = (strict < last) ? strict : last;
        if (lvl != raw) held++;
      end
    end
    last_lvl[idx] = lvl;
    e.level       = lvl;
    e.near_scaled = dlch_pkg::NEAR_W'((radius_m(0) * scale_q8) >> 8);
    expected_levels.push_back(e);
    requests++;
  endfunction

  function void check_word(logic [dlch_pkg::OUT_DATA_W-1:0] w);
    level_word_t e;
    if (expected_levels.size() == 0) begin
      $error("unexpected output word %h", w);
      errors++;
      return;
    end
    e = expected_levels.pop_front();
    checked++;
    if (w[1:0] !== e.level) begin
      $error("level: expected %0d, got %0d", e.level, w[1:0]);
      errors++;
    end
    if (w[18:2] !== e.near_scaled) begin
      $error("scaled_near_distance: expected %0d, got %0d", e.near_scaled, w[18:2]);
      errors++;
    end
  endfunction

  function int pending();
    return expected_levels.size();
  endfunction
endclass

module tb_distance_level_classifier_hysteresis;
  import dlch_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RDY_ALWAYS   = 0;
  localparam int RDY_RANDOM   = 1;
  localparam int RDY_PATTERN  = 2;
  localparam int RDY_SPARSE   = 3;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // entity_index, distance_m, moving, priority_req
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // level, scaled_near_distance

  level_checker sb;
  int           cycle_count;
  int           rdy_mode;
  int           settings;
  logic [15:0]  rdy_pat;

  distance_level_classifier_hysteresis u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk) begin
    case (rdy_mode)
      RDY_ALWAYS: m_tready <= 1'b1;
      RDY_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
      RDY_PATTERN: begin
        rdy_pat  <= {rdy_pat[14:0], rdy_pat[15]};
        m_tready <= rdy_pat[15];
      end
      default: m_tready <= ($urandom_range(0, 11) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata);
  end

  function automatic logic [IN_DATA_W-1:0] pack_req(int unsigned idx, int unsigned d,
                                                    bit mov, bit pri);
    return {6'b0, pri, mov, d[15:0], idx[7:0]};
  endfunction

  function automatic logic [IN_DATA_W-1:0] random_req();
    int unsigned idx;
    int          d, span;
    bit          mov, pri;
    idx = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 7) : $urandom_range(0, 255);
    mov = ($urandom_range(0, 9) < 7);
    pri = ($urandom_range(0, 9) == 0);
    span = int'(sb.margin_m) + 8;
    case ($urandom_range(0, 6))
      0, 1: d = int'(sb.scaled_m(0)) + int'($urandom_range(0, 2 * span)) - span;
      2:    d = int'(sb.scaled_m(1)) + int'($urandom_range(0, 2 * span)) - span;
      3:    d = int'(sb.scaled_m(2)) + int'($urandom_range(0, 2 * span)) - span;
      4:    d = $urandom_range(0, 65535);
      5:    d = $urandom_range(0, 255);
      default: d = 65535 - int'($urandom_range(0, 255));
    endcase
    if (d < 0) d = 0;
    if (d > 65535) d = 65535;
    return pack_req(idx, d, mov, pri);
  endfunction

  task automatic send_word(logic [IN_DATA_W-1:0] w);
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(w);
    @(negedge clk);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic apply_config(logic [15:0] nr, logic [15:0] md, logic [15:0] fr,
                              logic [15:0] sc, logic [15:0] mg);
    drain();
    cfg_put(CFG_NEAR, nr);
    cfg_put(CFG_MID, md);
    cfg_put(CFG_FAR, fr);
    cfg_put(CFG_SCALE, sc);
    cfg_put(CFG_MARGIN, mg);
    // indexes past the list must be ignored
    for (int i = int'(CFG_MARGIN) + 1; i < 2 ** CFG_IDX_W; i++) begin
      cfg_put(CFG_IDX_W'(i), CFG_DATA_W'($urandom_range(0, 65535)));
    end
    cfg_we <= 1'b0;
    @(negedge clk);
    settings++;
  endtask

  task automatic random_run(int n, int mode, int gmax);
    int left, burst;
    rdy_mode = mode;
    rdy_pat  = 16'(($urandom_range(1, 65535)) | 1);
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && left > 0) begin
        send_word(random_req());
        burst--;
        left--;
      end
      if (gmax > 0) idle_gap($urandom_range(0, gmax));
    end
  endtask

  task automatic directed_run();
    rdy_mode = RDY_ALWAYS;
    send_word(pack_req(0, 65535, 0, 1));
    send_word(pack_req(1, 0, 1, 0));
    send_word(pack_req(1, 600, 1, 0));
    send_word(pack_req(1, 480, 1, 0));   // held inside margin
    send_word(pack_req(1, 440, 1, 0));
    idle_gap(3);
    send_word(pack_req(2, 10001, 0, 0));
    send_word(pack_req(2, 9990, 0, 0));
    send_word(pack_req(2, 9950, 0, 0));
    send_word(pack_req(2, 2500, 1, 0));
    send_word(pack_req(2, 1960, 1, 0));
    send_word(pack_req(2, 1949, 1, 0));
    idle_gap(1);
    send_word(pack_req(255, 65535, 0, 0));
    send_word(pack_req(255, 0, 1, 1));   // priority clears stored level
    send_word(pack_req(255, 499, 1, 0));
    send_word(pack_req(128, 500, 1, 0));
    send_word(pack_req(128, 1999, 1, 0));
    send_word(pack_req(128, 2000, 1, 0));
    send_word(pack_req(127, 10000, 0, 0));
    send_word(pack_req(127, 0, 0, 1));
    send_word(pack_req(170, 16'hAAAA, 1, 0));
    send_word(pack_req(85, 16'h5555, 0, 0));
    drain();
  endtask

  task automatic random_config();
    logic [15:0] sc;
    sc = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                     : 16'($urandom_range(60, 400));
    apply_config(16'($urandom_range(0, 4000)), 16'($urandom_range(0, 9000)),
                 16'($urandom_range(0, 40000)), sc, 16'($urandom_range(0, 800)));
  endtask

  initial begin
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    m_tready    = 1'b0;
    cycle_count = 0;
    rdy_mode    = RDY_ALWAYS;
    rdy_pat     = 16'hA5C3;
    settings    = 1;
    sb          = new();
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed_run();
    random_run(60, RDY_RANDOM, 4);

    apply_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    random_run(60, RDY_PATTERN, 3);

    apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_run(60, RDY_RANDOM, 0);

    apply_config(16'hFFFF, 16'h0000, 16'h0000, 16'd76, 16'h0FFF);
    random_run(50, RDY_SPARSE, 2);

    apply_config(16'd50, 16'd150, 16'd650, 16'd385, 16'd1);
    random_run(60, RDY_ALWAYS, 6);

    random_config();
    random_run(30, RDY_PATTERN, 0);
    drain();   // sender holds off until every word is back
    random_run(30, RDY_RANDOM, 5);

    random_config();
    random_run(60, RDY_ALWAYS, 0);

    random_config();
    random_run(60, RDY_RANDOM, 8);

    random_config();
    random_run(60, RDY_PATTERN, 2);

    drain();
    $display("run covered %0d requests over %0d register settings", sb.requests, settings);
    $display("%0d words checked, %0d levels held back by hysteresis", sb.checked, sb.held);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
